// ----- rtl/cdq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and constants for the circular deque
// Depth, field widths, operation and status codes, and the cell control code.
// ----------------------------------------------------------------------------
package cdq_pkg;

   localparam int DEPTH  = 8;
   localparam int DATA_W = 32;
   localparam int OCC_W  = 4;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [CNT_W-1:0]         count_type;
   typedef logic [OCC_W-1:0]         occ_type;

   // requested operation
   typedef enum logic [1:0] {
      KIND_PUSH_BACK  = 2'd0,
      KIND_PUSH_FRONT = 2'd1,
      KIND_POP_BACK   = 2'd2,
      KIND_POP_FRONT  = 2'd3
   } kind_type;

   // transaction outcome
   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // what one cell takes in at the next edge
   typedef enum logic [1:0] {
      CELL_HOLD       = 2'd0,
      CELL_LOAD       = 2'd1,
      CELL_FROM_LEFT  = 2'd2,
      CELL_FROM_RIGHT = 2'd3
   } cell_op_type;

   // per-cell control bundle
   typedef struct packed {
      cell_op_type op;
      logic        is_back;
   } cell_ctrl_type;

   // report the count modulo 2**OCC_W
   function automatic occ_type occ_of(input count_type count);
      logic [CNT_W+OCC_W-1:0] ext;
      ext = {{OCC_W{1'b0}}, count};
      return ext[OCC_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ----- rtl/circular_deque.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// circular_deque: double-ended queue in a chain of storage cells
// A result appears in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle; busy stays low, since every
//   operation is one broadcast shift or load across the cell chain.
// Results cannot be stalled: each sits on the rsp_ ports for one cycle.
// Reset clears the entry count and the result strobe; cell data stays as is.
// ----------------------------------------------------------------------------
module circular_deque (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   output logic                    busy,
   input  wire  [1:0]              req_kind,
   input  wire  signed [31:0]      req_value,
   output logic                    rsp_strobe,
   output logic signed [31:0]      rsp_popped,
   output logic [1:0]              rsp_status,
   output logic [3:0]              rsp_occupancy
);
   import cdq_pkg::*;

   count_type     count_ff;
   count_type     count_in;
   logic          rsp_strobe_ff;
   data_type      popped_ff;
   data_type      popped_in;
   status_type    status_ff;
   status_type    status_in;
   occ_type       occ_ff;

   kind_type      kind;
   logic          is_push;
   logic          is_empty;
   logic          is_full;
   logic          accept;
   logic          push_ok;
   logic          pop_ok;
   data_type      back_value;

   cell_ctrl_type ctrl  [DEPTH];
   data_type      value [DEPTH];
   data_type      tap   [DEPTH];

   assign kind     = kind_type'(req_kind);
   assign is_push  = (kind == KIND_PUSH_BACK) || (kind == KIND_PUSH_FRONT);
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == count_type'(DEPTH));
   assign accept   = start && !busy;
   assign push_ok  = accept && is_push && !is_full;
   assign pop_ok   = accept && !is_push && !is_empty;

   // drive per-cell control
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         ctrl[i].is_back = (count_ff == count_type'(i + 1));
         ctrl[i].op      = CELL_HOLD;
         if (push_ok && kind == KIND_PUSH_BACK) begin
            if (count_ff == count_type'(i)) begin
               ctrl[i].op = CELL_LOAD;
            end
         end else if (push_ok && kind == KIND_PUSH_FRONT) begin
            ctrl[i].op = (i == 0) ? CELL_LOAD : CELL_FROM_LEFT;
         end else if (pop_ok && kind == KIND_POP_FRONT) begin
            ctrl[i].op = CELL_FROM_RIGHT;
         end
      end
   end

   // build the cell chain
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      data_type left_v;
      data_type right_v;
      if (g == 0) begin : g_first
         assign left_v = req_value;
      end else begin : g_mid_l
         assign left_v = value[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign right_v = value[g];
      end else begin : g_mid_r
         assign right_v = value[g+1];
      end
      cdq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl[g]),
         .new_value   (req_value),
         .left_value  (left_v),
         .right_value (right_v),
         .value       (value[g]),
         .back_tap    (tap[g])
      );
   end

   // merge the back taps; only the back cell drives a nonzero tap
   always_comb begin
      back_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         back_value = back_value | tap[i];
      end
   end

   // compute outcome and next count
   always_comb begin
      count_in  = count_ff;
      popped_in = '0;
      status_in = STATUS_DONE;
      if (accept) begin
         if (is_push) begin
            if (is_full) begin
               status_in = STATUS_FULL;
            end else begin
               count_in = count_ff + count_type'(1);
            end
         end else begin
            if (is_empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               count_in  = count_ff - count_type'(1);
               popped_in = (kind == KIND_POP_FRONT) ? value[0] : back_value;
            end
         end
      end
   end

   // advance count and result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= accept;
      end
   end

   // hold result payload
   always_ff @(posedge clock) begin
      popped_ff <= popped_in;
      status_ff <= status_in;
      occ_ff    <= occ_of(count_in);
   end

   assign busy          = 1'b0;
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_popped    = popped_ff;
   assign rsp_status    = status_ff;
   assign rsp_occupancy = occ_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= count_type'(DEPTH))
      else $error("entry count above depth");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_strobe)
      else $error("accepted transaction without result");

   a_full_refusal: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == STATUS_FULL) |->
         (count_ff == count_type'(DEPTH) && rsp_popped == '0))
      else $error("full refusal while not full");

   a_empty_refusal: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == STATUS_EMPTY) |->
         (count_ff == '0 && rsp_popped == '0))
      else $error("empty refusal while not empty");
`endif

endmodule
`default_nettype wire

// ----- rtl/cdq_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_cell: one storage cell of the deque chain
// Holds one entry; loads a new value or takes a neighbor's entry on a shift,
// and drives its entry onto the back tap when it holds the back entry.
// ----------------------------------------------------------------------------
module cdq_cell (
   input  wire                          clock,
   input  wire cdq_pkg::cell_ctrl_type  ctrl,
   input  wire cdq_pkg::data_type       new_value,
   input  wire cdq_pkg::data_type       left_value,
   input  wire cdq_pkg::data_type       right_value,
   output cdq_pkg::data_type            value,
   output cdq_pkg::data_type            back_tap
);
   import cdq_pkg::*;

   data_type value_ff;
   data_type value_in;

   // select the next entry
   always_comb begin
      case (ctrl.op)
         CELL_HOLD:       value_in = value_ff;
         CELL_LOAD:       value_in = new_value;
         CELL_FROM_LEFT:  value_in = left_value;
         CELL_FROM_RIGHT: value_in = right_value;
         default:         value_in = value_ff;
      endcase
   end

   // hold the entry
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value    = value_ff;
   assign back_tap = ctrl.is_back ? value_ff : '0;

endmodule
`default_nettype wire

// ----- sim/circular_deque_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_tb: self-checking bench for the circular deque
// Directed pushes and pops at both ends (empty, full, last entry, value
// extremes) are followed by random fill and drain runs. A local copy of the
// deque predicts every response, and the monitor checks each strobed result.
// ----------------------------------------------------------------------------
module circular_deque_tb;
   import cdq_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_OPS     = 575;
   localparam int DRAIN_CYCLES   = 8;

   // one queued transaction, with the chance that the driver idles before it
   typedef struct {
      kind_type kind;
      data_type value;
      int       gap_pct;
   } deque_op_t;

   // one predicted response
   typedef struct {
      data_type   popped;
      status_type status;
      occ_type    occupancy;
   } deque_rsp_t;

   logic     clock     = 1'b0;
   logic     reset     = 1'b1;
   logic     start     = 1'b0;
   kind_type req_kind  = KIND_PUSH_BACK;
   data_type req_value = '0;

   wire                busy;
   wire                rsp_strobe;
   wire signed [31:0]  rsp_popped;
   wire [1:0]          rsp_status;
   wire [3:0]          rsp_occupancy;

   deque_op_t  queued_ops[$];
   deque_rsp_t predicted_replies[$];
   deque_op_t  next_op;
   deque_rsp_t got_reply;

   // local copy of the deque
   data_type model_slots [DEPTH];
   int       model_front = 0;
   int       model_back  = 0;
   logic     model_empty = 1'b1;

   logic item_taken  = 1'b0;
   int   idle_cycles = 0;
   int   error_count = 0;
   int   fill_level  = 0;

   circular_deque dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_kind      (req_kind),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_popped    (rsp_popped),
      .rsp_status    (rsp_status),
      .rsp_occupancy (rsp_occupancy)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // apply one operation to the local deque and return the expected response
   function automatic deque_rsp_t apply_deque_op(kind_type kind, data_type value);
      deque_rsp_t r;
      int         count;
      r.popped = '0;
      r.status = STATUS_DONE;
      if (kind == KIND_PUSH_BACK || kind == KIND_PUSH_FRONT) begin
         if (model_empty) begin
            // first entry always lands in slot zero
            model_front    = 0;
            model_back     = 0;
            model_slots[0] = value;
            model_empty    = 1'b0;
         end else if ((model_back + 1) % DEPTH == model_front) begin
            r.status = STATUS_FULL;
         end else if (kind == KIND_PUSH_BACK) begin
            model_back              = (model_back + 1) % DEPTH;
            model_slots[model_back] = value;
         end else begin
            model_front              = (model_front + DEPTH - 1) % DEPTH;
            model_slots[model_front] = value;
         end
      end else begin
         if (model_empty) begin
            r.status = STATUS_EMPTY;
         end else if (model_front == model_back) begin
            // last entry leaves: rewind both ends
            r.popped    = model_slots[model_front];
            model_front = 0;
            model_back  = 0;
            model_empty = 1'b1;
         end else if (kind == KIND_POP_BACK) begin
            r.popped   = model_slots[model_back];
            model_back = (model_back + DEPTH - 1) % DEPTH;
         end else begin
            r.popped    = model_slots[model_front];
            model_front = (model_front + 1) % DEPTH;
         end
      end
      count = model_empty ? 0 : ((model_back + DEPTH - model_front) % DEPTH) + 1;
      r.occupancy = occ_type'(count);
      return r;
   endfunction

   // queue one operation and track how full the deque will be
   task automatic add_op(kind_type kind, data_type value, int gap_pct);
      deque_op_t op;
      op.kind    = kind;
      op.value   = value;
      op.gap_pct = gap_pct;
      queued_ops.push_back(op);
      if (kind == KIND_PUSH_BACK || kind == KIND_PUSH_FRONT) begin
         if (fill_level < DEPTH) fill_level++;
      end else if (fill_level > 0) begin
         fill_level--;
      end
   endtask

   function automatic data_type random_value();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return '0;
         3: return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   // drive the next transaction at the falling edge; hold it until taken
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !item_taken) begin
         start <= 1'b1;
      end else if (queued_ops.size() != 0 && $urandom_range(99) >= queued_ops[0].gap_pct) begin
         next_op   = queued_ops.pop_front();
         start     <= 1'b1;
         req_kind  <= next_op.kind;
         req_value <= next_op.value;
      end else begin
         start <= 1'b0;
      end
   end

   // predict accepted transactions, then check strobed results
   always @(posedge clock) begin
      if (reset) begin
         item_taken <= 1'b0;
      end else begin
         item_taken <= start && !busy;
         if (start && !busy)
            predicted_replies.push_back(apply_deque_op(req_kind, req_value));
         if (rsp_strobe) begin
            if (predicted_replies.size() == 0) begin
               $display("%0t: unexpected result popped=%0d status=%0d occupancy=%0d",
                        $time, rsp_popped, rsp_status, rsp_occupancy);
               error_count++;
            end else begin
               got_reply = predicted_replies.pop_front();
               if (rsp_popped !== got_reply.popped) begin
                  $display("%0t: popped expected %0d actual %0d",
                           $time, got_reply.popped, rsp_popped);
                  error_count++;
               end
               if (rsp_status !== got_reply.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, got_reply.status, rsp_status);
                  error_count++;
               end
               if (rsp_occupancy !== got_reply.occupancy) begin
                  $display("%0t: occupancy expected %0d actual %0d",
                           $time, got_reply.occupancy, rsp_occupancy);
                  error_count++;
               end
            end
         end
      end
   end

   // stop a hung run: count cycles with no transaction in either direction
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("circular_deque verification failed");
            $finish;
         end
      end
   end

   initial begin
      int   gap;
      logic filling;
      for (int i = 0; i < DEPTH; i++) model_slots[i] = '0;

      // pops from empty, then a single entry in and out at each end
      add_op(KIND_POP_BACK, 32'h1234_5678, 33);
      add_op(KIND_POP_FRONT, 32'h8765_4321, 33);
      add_op(KIND_PUSH_FRONT, 32'h7FFF_FFFF, 33);
      add_op(KIND_POP_BACK, '0, 33);
      add_op(KIND_PUSH_BACK, 32'h8000_0000, 33);
      add_op(KIND_POP_FRONT, '0, 33);

      // fill from both ends, then push into the full deque at each end
      for (int i = 0; i < DEPTH; i++)
         add_op((i % 2) ? KIND_PUSH_FRONT : KIND_PUSH_BACK,
                (i == 0) ? 32'h5555_5555 : (i == 1) ? 32'hAAAA_AAAA :
                (i == 2) ? 32'hFFFF_FFFF : $urandom(), 33);
      add_op(KIND_PUSH_BACK, 32'h0F0F_0F0F, 33);
      add_op(KIND_PUSH_FRONT, 32'hF0F0_F0F0, 33);

      // drain alternately, ending on the last entry and one more pop
      for (int i = 0; i < DEPTH; i++)
         add_op((i % 2) ? KIND_POP_FRONT : KIND_POP_BACK, $urandom(), 33);
      add_op(KIND_POP_FRONT, '0, 33);

      // random fill and drain runs; mostly well-formed, some noise
      filling = 1'b1;
      for (int i = 0; i < RANDOM_OPS; i++) begin
         gap = (i < RANDOM_OPS / 3) ? 33 : (i < 2 * RANDOM_OPS / 3) ? 84 : 0;
         if (fill_level == DEPTH && $urandom_range(1)) filling = 1'b0;
         if (fill_level == 0 && $urandom_range(1)) filling = 1'b1;
         if ($urandom_range(19) == 0) filling = !filling;
         if (($urandom_range(99) < 75) == filling)
            add_op($urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK,
                   random_value(), gap);
         else
            add_op($urandom_range(1) ? KIND_POP_FRONT : KIND_POP_BACK,
                   random_value(), gap);
      end

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // wait for all stimulus to go in and every result to come back
      while (queued_ops.size() != 0 || start) @(posedge clock);
      while (predicted_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (predicted_replies.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, predicted_replies.size());
         error_count++;
      end
      if (error_count == 0)
         $display("circular_deque verification clean");
      else
         $display("circular_deque verification failed");
      $finish;
   end

endmodule
